[design/ptsa_pkg.sv]
// shared constants and types for the per-type slot allocator
`default_nettype none

package ptsa_pkg;

   localparam int MAX_SLOTS  = 128;
   localparam int POOL_COUNT = 3;
   localparam int CFG_COUNT  = 3;

   // pools that can be addressed: limited by both the pool count and the capacity registers
   localparam int NUM_POOLS = (POOL_COUNT < CFG_COUNT) ? POOL_COUNT : CFG_COUNT;
   localparam int POOL_W    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int CFG_IDX_W = (CFG_COUNT > 1) ? $clog2(CFG_COUNT) : 1;

   localparam int SLOT_W    = 7;
   localparam int TYPE_W    = 2;
   localparam int CAP_W     = 8;
   localparam int CSR_IDX_W = 2;

   localparam int PTR_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
   localparam int LIM_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int MEM_DEPTH = NUM_POOLS * MAX_SLOTS;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   localparam logic [CAP_W-1:0] CAP_RESET [CFG_COUNT] = '{8'd12, 8'd128, 8'd1};

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_BAD_TYPE  = 2'd2,
      ST_LIST_FULL = 2'd3
   } status_type;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

endpackage

`default_nettype wire

[design/per_type_slot_allocator_top.sv]
// per-type slot allocator: fifo free lists in one memory plus bump counters per pool
// the result strobe rises in the cycle after the item is taken.
// throughput: one item per cycle; busy stays low, since each item touches a single
// free-list entry (read or write, never both) and pointers and counters sit in flops.
// the free-list memory read port is registered, and its output lines up with the result strobe.
// reset: synchronous, clears pointers, fill counts and bump counters and reloads the
// capacities; memory contents are not cleared, no entry is read before it is written.
`default_nettype none

module per_type_slot_allocator_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_action,
   input  wire logic [ptsa_pkg::TYPE_W-1:0]     req_heap_type,
   input  wire logic [ptsa_pkg::SLOT_W-1:0]     req_slot_in,
   output logic                                 rsp_valid,
   output logic [ptsa_pkg::SLOT_W-1:0]          rsp_slot_out,
   output logic [1:0]                           rsp_status,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ptsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ptsa_pkg::CAP_W-1:0]      csr_wdata
);

   // configuration
   logic [ptsa_pkg::CAP_W-1:0] cap_ff [ptsa_pkg::CFG_COUNT];

   // per-pool control state
   logic [ptsa_pkg::CNT_W-1:0] bump_ff [ptsa_pkg::NUM_POOLS];
   logic [ptsa_pkg::CNT_W-1:0] bump_in [ptsa_pkg::NUM_POOLS];
   logic [ptsa_pkg::PTR_W-1:0] head_ff [ptsa_pkg::NUM_POOLS];
   logic [ptsa_pkg::PTR_W-1:0] head_in [ptsa_pkg::NUM_POOLS];
   logic [ptsa_pkg::PTR_W-1:0] tail_ff [ptsa_pkg::NUM_POOLS];
   logic [ptsa_pkg::PTR_W-1:0] tail_in [ptsa_pkg::NUM_POOLS];
   logic [ptsa_pkg::CNT_W-1:0] fill_ff [ptsa_pkg::NUM_POOLS];
   logic [ptsa_pkg::CNT_W-1:0] fill_in [ptsa_pkg::NUM_POOLS];

   // free-list memory
   logic [ptsa_pkg::SLOT_W-1:0] fq_mem [ptsa_pkg::MEM_DEPTH];
   logic [ptsa_pkg::SLOT_W-1:0] rd_data_ff;

   // response stage
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_from_mem_ff;
   logic                        rsp_from_mem_in;
   logic [ptsa_pkg::SLOT_W-1:0] rsp_slot_ff;
   logic [ptsa_pkg::SLOT_W-1:0] rsp_slot_in;
   ptsa_pkg::status_type        rsp_status_ff;
   ptsa_pkg::status_type        rsp_status_in;

   logic                         accept;
   logic                         pool_ok;
   logic [ptsa_pkg::POOL_W-1:0]  pool_sel;
   logic [ptsa_pkg::LIM_W-1:0]   cap_ext;
   logic [ptsa_pkg::LIM_W-1:0]   limit;
   logic [ptsa_pkg::ADDR_W-1:0]  pool_base;
   logic [ptsa_pkg::ADDR_W-1:0]  mem_addr;
   logic                         mem_rd;
   logic                         mem_wr;
   logic                         fill_over;
   logic                         bump_over;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   function automatic logic [ptsa_pkg::PTR_W-1:0] ptr_next(
      input logic [ptsa_pkg::PTR_W-1:0] ptr
   );
      logic [ptsa_pkg::PTR_W-1:0] nxt;
      if (ptr == ptsa_pkg::PTR_W'(ptsa_pkg::MAX_SLOTS - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   always_comb begin
      pool_ok   = ({1'b0, req_heap_type} < (ptsa_pkg::TYPE_W + 1)'(ptsa_pkg::NUM_POOLS));
      pool_sel  = pool_ok ? ptsa_pkg::POOL_W'(req_heap_type) : '0;
      cap_ext   = ptsa_pkg::LIM_W'(cap_ff[ptsa_pkg::CFG_IDX_W'(pool_sel)]);
      limit     = (cap_ext < ptsa_pkg::LIM_W'(ptsa_pkg::MAX_SLOTS)) ?
                  cap_ext : ptsa_pkg::LIM_W'(ptsa_pkg::MAX_SLOTS);
      pool_base = ptsa_pkg::ADDR_W'(pool_sel) * ptsa_pkg::ADDR_W'(ptsa_pkg::MAX_SLOTS);

      bump_in         = bump_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      fill_in         = fill_ff;
      mem_rd          = 1'b0;
      mem_wr          = 1'b0;
      mem_addr        = pool_base + ptsa_pkg::ADDR_W'(head_ff[pool_sel]);
      rsp_valid_in    = accept;
      rsp_from_mem_in = 1'b0;
      rsp_slot_in     = '0;
      rsp_status_in   = ptsa_pkg::ST_OK;

      if (accept) begin
         if (!pool_ok) begin
            rsp_status_in = ptsa_pkg::ST_BAD_TYPE;
         end else if (ptsa_pkg::action_type'(req_action) == ptsa_pkg::ACT_ALLOC) begin
            if (fill_ff[pool_sel] != '0) begin
               // oldest freed index comes out of the memory next cycle
               mem_rd            = 1'b1;
               rsp_from_mem_in   = 1'b1;
               head_in[pool_sel] = ptr_next(head_ff[pool_sel]);
               fill_in[pool_sel] = fill_ff[pool_sel] - 1'b1;
            end else if (ptsa_pkg::LIM_W'(bump_ff[pool_sel]) < limit) begin
               rsp_slot_in       = ptsa_pkg::SLOT_W'(bump_ff[pool_sel]);
               bump_in[pool_sel] = bump_ff[pool_sel] + 1'b1;
            end else begin
               rsp_status_in = ptsa_pkg::ST_EXHAUSTED;
            end
         end else begin
            if (fill_ff[pool_sel] >= ptsa_pkg::CNT_W'(ptsa_pkg::MAX_SLOTS)) begin
               rsp_status_in = ptsa_pkg::ST_LIST_FULL;
            end else begin
               mem_wr            = 1'b1;
               mem_addr          = pool_base + ptsa_pkg::ADDR_W'(tail_ff[pool_sel]);
               tail_in[pool_sel] = ptr_next(tail_ff[pool_sel]);
               fill_in[pool_sel] = fill_ff[pool_sel] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ptsa_pkg::CFG_COUNT; i++) begin
            cap_ff[i] <= ptsa_pkg::CAP_RESET[i];
         end
         for (int i = 0; i < ptsa_pkg::NUM_POOLS; i++) begin
            bump_ff[i] <= '0;
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         rsp_valid_ff    <= 1'b0;
         rsp_from_mem_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready &&
             ({1'b0, csr_index} < (ptsa_pkg::CSR_IDX_W + 1)'(ptsa_pkg::CFG_COUNT))) begin
            cap_ff[ptsa_pkg::CFG_IDX_W'(csr_index)] <= csr_wdata;
         end
         bump_ff         <= bump_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         fill_ff         <= fill_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_from_mem_ff <= rsp_from_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   // one access per item: either the read for an allocate or the write for a free
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         fq_mem[mem_addr] <= req_slot_in;
      end
      if (mem_rd) begin
         rd_data_ff <= fq_mem[mem_addr];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_slot_out = rsp_from_mem_ff ? rd_data_ff : rsp_slot_ff;
   assign rsp_status   = rsp_status_ff;

   always_comb begin
      fill_over = 1'b0;
      bump_over = 1'b0;
      for (int i = 0; i < ptsa_pkg::NUM_POOLS; i++) begin
         if (fill_ff[i] > ptsa_pkg::CNT_W'(ptsa_pkg::MAX_SLOTS)) begin
            fill_over = 1'b1;
         end
         if (bump_ff[i] > ptsa_pkg::CNT_W'(ptsa_pkg::MAX_SLOTS)) begin
            bump_over = 1'b1;
         end
      end
   end

   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item produced no result strobe");

   a_no_rsp_without_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("result strobe without an accepted item");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      !fill_over)
      else $error("free list fill count above pool size");

   a_bump_bounded: assert property (@(posedge clock) disable iff (reset)
      !bump_over)
      else $error("bump counter above pool size");

   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ptsa_pkg::ST_OK) |-> (rsp_slot_out == '0))
      else $error("failed item returned a nonzero slot");

endmodule

`default_nettype wire

[tb/per_type_slot_allocator_top_tb.sv]
// self-checking testbench for the per-type slot allocator: directed table, then random traffic
`default_nettype none

module per_type_slot_allocator_top_tb;

   localparam logic [ptsa_pkg::TYPE_W-1:0] HEAP_RT  = 2'd0;
   localparam logic [ptsa_pkg::TYPE_W-1:0] HEAP_SR  = 2'd1;
   localparam logic [ptsa_pkg::TYPE_W-1:0] HEAP_DS  = 2'd2;
   localparam logic [ptsa_pkg::TYPE_W-1:0] HEAP_BAD = 2'd3;

   localparam logic [ptsa_pkg::CSR_IDX_W-1:0] REG_CAP_RT     = 2'd0;
   localparam logic [ptsa_pkg::CSR_IDX_W-1:0] REG_CAP_SR     = 2'd1;
   localparam logic [ptsa_pkg::CSR_IDX_W-1:0] REG_CAP_DS     = 2'd2;
   localparam logic [ptsa_pkg::CSR_IDX_W-1:0] REG_UNUSED     = 2'd3;

   localparam int STALL_LIMIT = 2000;
   localparam int N_ROWS      = 22;
   localparam int PEND_DEPTH  = 8;

   typedef struct packed {
      logic [ptsa_pkg::SLOT_W-1:0] slot;
      ptsa_pkg::status_type        status;
   } reply_type;

   typedef struct packed {
      ptsa_pkg::action_type        act;
      logic [ptsa_pkg::TYPE_W-1:0] heap;
      logic [ptsa_pkg::SLOT_W-1:0] slot;
      logic                        fixed;
      logic [ptsa_pkg::SLOT_W-1:0] want_slot;
      ptsa_pkg::status_type        want_status;
   } row_type;

   // fixed expectations only where they follow directly from reset capacities 12 / 128 / 1
   row_type directed_rows [N_ROWS] = '{
      '{ptsa_pkg::ACT_ALLOC, HEAP_RT,  7'd0,   1'b1, 7'd0,   ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_ALLOC, HEAP_SR,  7'd0,   1'b1, 7'd0,   ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_ALLOC, HEAP_DS,  7'd127, 1'b1, 7'd0,   ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_ALLOC, HEAP_DS,  7'd0,   1'b1, 7'd0,   ptsa_pkg::ST_EXHAUSTED},
      '{ptsa_pkg::ACT_ALLOC, HEAP_BAD, 7'd0,   1'b1, 7'd0,   ptsa_pkg::ST_BAD_TYPE},
      '{ptsa_pkg::ACT_FREE,  HEAP_BAD, 7'd127, 1'b1, 7'd0,   ptsa_pkg::ST_BAD_TYPE},
      '{ptsa_pkg::ACT_FREE,  HEAP_DS,  7'd127, 1'b1, 7'd0,   ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_ALLOC, HEAP_DS,  7'd0,   1'b1, 7'd127, ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_ALLOC, HEAP_DS,  7'd0,   1'b1, 7'd0,   ptsa_pkg::ST_EXHAUSTED},
      '{ptsa_pkg::ACT_FREE,  HEAP_RT,  7'd85,  1'b1, 7'd0,   ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_FREE,  HEAP_RT,  7'd85,  1'b1, 7'd0,   ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_FREE,  HEAP_RT,  7'd42,  1'b1, 7'd0,   ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_ALLOC, HEAP_RT,  7'd0,   1'b1, 7'd85,  ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_ALLOC, HEAP_RT,  7'd127, 1'b1, 7'd85,  ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_ALLOC, HEAP_RT,  7'd0,   1'b1, 7'd42,  ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_ALLOC, HEAP_RT,  7'd0,   1'b1, 7'd1,   ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_FREE,  HEAP_SR,  7'd0,   1'b0, 7'd0,   ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_ALLOC, HEAP_SR,  7'd0,   1'b0, 7'd0,   ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_ALLOC, HEAP_SR,  7'd85,  1'b0, 7'd0,   ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_FREE,  HEAP_SR,  7'd127, 1'b0, 7'd0,   ptsa_pkg::ST_OK},
      '{ptsa_pkg::ACT_ALLOC, HEAP_BAD, 7'd127, 1'b1, 7'd0,   ptsa_pkg::ST_BAD_TYPE},
      '{ptsa_pkg::ACT_ALLOC, HEAP_SR,  7'd0,   1'b0, 7'd0,   ptsa_pkg::ST_OK}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic                           req_action = 1'b0;
   logic [ptsa_pkg::TYPE_W-1:0]    req_heap_type = '0;
   logic [ptsa_pkg::SLOT_W-1:0]    req_slot_in = '0;
   logic                           rsp_valid;
   logic [ptsa_pkg::SLOT_W-1:0]    rsp_slot_out;
   logic [1:0]                     rsp_status;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [ptsa_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ptsa_pkg::CAP_W-1:0]     csr_wdata = '0;

   // typed expectation that travels with the current item
   logic                 row_fixed = 1'b0;
   reply_type            row_reply = '0;

   // predictor state
   logic [ptsa_pkg::CAP_W-1:0]  pool_capacity [ptsa_pkg::CFG_COUNT];
   logic [7:0]                  bump_next     [ptsa_pkg::NUM_POOLS];
   logic [ptsa_pkg::SLOT_W-1:0] freed_slots   [ptsa_pkg::NUM_POOLS][ptsa_pkg::MAX_SLOTS];
   logic [ptsa_pkg::PTR_W-1:0]  freed_head    [ptsa_pkg::NUM_POOLS];
   logic [ptsa_pkg::PTR_W-1:0]  freed_tail    [ptsa_pkg::NUM_POOLS];
   logic [7:0]                  freed_fill    [ptsa_pkg::NUM_POOLS];

   // predicted results waiting for their strobe, oldest at pend_rd
   reply_type  pend_buf [PEND_DEPTH];
   logic [2:0] pend_rd      = '0;
   logic [2:0] pend_wr      = '0;
   int         pend_count   = 0;
   int         items_sent   = 0;
   int         replies_seen = 0;
   int         fail_count   = 0;
   int         quiet_cycles = 0;
   int         idle_pct     = 14;

   per_type_slot_allocator_top dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_heap_type (req_heap_type),
      .req_slot_in   (req_slot_in),
      .rsp_valid     (rsp_valid),
      .rsp_slot_out  (rsp_slot_out),
      .rsp_status    (rsp_status),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic clear_pools();
      for (int p = 0; p < ptsa_pkg::CFG_COUNT; p++) pool_capacity[p] = ptsa_pkg::CAP_RESET[p];
      for (int p = 0; p < ptsa_pkg::NUM_POOLS; p++) begin
         bump_next[p]  = '0;
         freed_head[p] = '0;
         freed_tail[p] = '0;
         freed_fill[p] = '0;
      end
   endtask

   task automatic allocate_or_free(input ptsa_pkg::action_type act,
                                   input logic [ptsa_pkg::TYPE_W-1:0] heap,
                                   input logic [ptsa_pkg::SLOT_W-1:0] slot,
                                   output reply_type r);
      int p;
      int limit;
      p = heap;
      r.slot = '0;
      r.status = ptsa_pkg::ST_OK;
      if (p >= ptsa_pkg::NUM_POOLS) begin
         r.status = ptsa_pkg::ST_BAD_TYPE;
      end else if (act == ptsa_pkg::ACT_ALLOC) begin
         if (freed_fill[p] != 0) begin
            r.slot = freed_slots[p][freed_head[p]];
            freed_head[p] = freed_head[p] + 1'b1;
            freed_fill[p] = freed_fill[p] - 1'b1;
         end else begin
            limit = (pool_capacity[p] < ptsa_pkg::MAX_SLOTS) ?
                    pool_capacity[p] : ptsa_pkg::MAX_SLOTS;
            if (bump_next[p] < limit) begin
               r.slot = bump_next[p][ptsa_pkg::SLOT_W-1:0];
               bump_next[p] = bump_next[p] + 1'b1;
            end else begin
               r.status = ptsa_pkg::ST_EXHAUSTED;
            end
         end
      end else if (freed_fill[p] >= ptsa_pkg::MAX_SLOTS) begin
         r.status = ptsa_pkg::ST_LIST_FULL;
      end else begin
         freed_slots[p][freed_tail[p]] = slot;
         freed_tail[p] = freed_tail[p] + 1'b1;
         freed_fill[p] = freed_fill[p] + 1'b1;
      end
   endtask

   // predict on every accepted item, check every result strobe against the oldest prediction
   always @(posedge clock) begin
      reply_type want;
      reply_type pred;
      if (reset) begin
         clear_pools();
         pend_rd    = '0;
         pend_wr    = '0;
         pend_count = 0;
      end else begin
         if (rsp_valid) begin
            replies_seen++;
            if (pend_count == 0) begin
               $error("unexpected result: slot_out %0d status %0d", rsp_slot_out, rsp_status);
               fail_count++;
            end else begin
               want    = pend_buf[pend_rd];
               pend_rd = pend_rd + 1'b1;
               pend_count--;
               if (rsp_slot_out !== want.slot) begin
                  $error("slot_out: expected %0d, actual %0d", want.slot, rsp_slot_out);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready && csr_index < ptsa_pkg::CFG_COUNT)
            pool_capacity[csr_index] = csr_wdata;
         if (start && !busy) begin
            allocate_or_free(ptsa_pkg::action_type'(req_action), req_heap_type, req_slot_in,
                             pred);
            pend_buf[pend_wr] = row_fixed ? row_reply : pred;
            pend_wr = pend_wr + 1'b1;
            pend_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_item(input ptsa_pkg::action_type act,
                            input logic [ptsa_pkg::TYPE_W-1:0] heap,
                            input logic [ptsa_pkg::SLOT_W-1:0] slot, input logic fixed,
                            input logic [ptsa_pkg::SLOT_W-1:0] want_slot,
                            input ptsa_pkg::status_type want_status);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_action    <= act;
      req_heap_type <= heap;
      req_slot_in   <= slot;
      row_fixed     <= fixed;
      row_reply     <= '{slot: want_slot, status: want_status};
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // every item gives one result, so idle means results caught up with items
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (replies_seen != items_sent) @(posedge clock);
   endtask

   task automatic program_register(input logic [ptsa_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [ptsa_pkg::CAP_W-1:0] val);
      while ($urandom_range(99) < idle_pct) begin
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_capacities(input logic [ptsa_pkg::CAP_W-1:0] cap_rt,
                                 input logic [ptsa_pkg::CAP_W-1:0] cap_sr,
                                 input logic [ptsa_pkg::CAP_W-1:0] cap_ds,
                                 input logic poke_unused);
      wait_drained();
      program_register(REG_CAP_RT, cap_rt);
      program_register(REG_CAP_SR, cap_sr);
      program_register(REG_CAP_DS, cap_ds);
      if (poke_unused) program_register(REG_UNUSED, ptsa_pkg::CAP_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic random_traffic(input int count, input int free_pct, input int focus,
                                 input int focus_pct, input int bad_pct);
      ptsa_pkg::action_type        act;
      logic [ptsa_pkg::TYPE_W-1:0] heap;
      logic [ptsa_pkg::SLOT_W-1:0] slot;
      int                          pick;
      for (int n = 0; n < count; n++) begin
         act = ($urandom_range(99) < free_pct) ? ptsa_pkg::ACT_FREE : ptsa_pkg::ACT_ALLOC;
         if ($urandom_range(99) < bad_pct) heap = HEAP_BAD;
         else if ($urandom_range(99) < focus_pct) heap = ptsa_pkg::TYPE_W'(focus);
         else heap = ptsa_pkg::TYPE_W'($urandom_range(ptsa_pkg::NUM_POOLS - 1));
         pick = $urandom_range(9);
         if (pick == 0) slot = '0;
         else if (pick == 1) slot = '1;
         else slot = ptsa_pkg::SLOT_W'($urandom);
         send_item(act, heap, slot, 1'b0, '0, ptsa_pkg::ST_OK);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_ROWS; i++)
         send_item(directed_rows[i].act, directed_rows[i].heap, directed_rows[i].slot,
                   directed_rows[i].fixed, directed_rows[i].want_slot,
                   directed_rows[i].want_status);

      random_traffic(40, 50, HEAP_RT, 30, 10);

      // flood one free list past full with no idle gaps
      set_capacities(8'd0, 8'd255, 8'd128, 1'b0);
      idle_pct = 0;
      random_traffic(200, 92, HEAP_SR, 85, 3);
      idle_pct = 14;

      // drain it again, run into exhausted pools and pointer wrap
      set_capacities(8'd128, 8'd200, 8'd0, 1'b0);
      random_traffic(200, 10, HEAP_SR, 85, 3);

      set_capacities(ptsa_pkg::CAP_W'($urandom_range(255)),
                     ptsa_pkg::CAP_W'($urandom_range(255)),
                     ptsa_pkg::CAP_W'($urandom_range(255)), 1'b0);
      random_traffic(40, 50, HEAP_DS, 30, 10);

      set_capacities(8'd1, 8'd3, 8'd255, 1'b1);
      random_traffic(40, 40, HEAP_RT, 40, 10);

      wait_drained();
      repeat (8) @(posedge clock);
      if (pend_count != 0) begin
         $error("%0d expected results never arrived", pend_count);
         fail_count++;
      end
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

[per_type_slot_allocator_top.f]
design/ptsa_pkg.sv
design/per_type_slot_allocator_top.sv
tb/per_type_slot_allocator_top_tb.sv
